// ===== design/hhfp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and helpers for the HTTP header field parser.
// No dependencies; imported by http_header_field_parser.
package hhfp_pkg;

    // Field widths of the request and result channels
    localparam int unsigned OP_W    = 2;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned ERR_W   = 3;
    localparam int unsigned NLEN_W  = 13;
    localparam int unsigned VLEN_W  = 17;
    localparam int unsigned FIDX_W  = 11;

    // Configuration register widths and index map
    localparam int unsigned MAXF_W  = 10;
    localparam int unsigned MAXN_W  = 12;
    localparam int unsigned MAXV_W  = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FIELDS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_NAME_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE_LEN = 2'd2;

    // Reset values of the limit registers
    localparam logic [MAXF_W-1:0] RST_MAX_FIELDS    = 10'd100;
    localparam logic [MAXN_W-1:0] RST_MAX_NAME_LEN  = 12'd256;
    localparam logic [MAXV_W-1:0] RST_MAX_VALUE_LEN = 16'd4096;

    // Default caps on written limits
    localparam int unsigned DEF_NAME_LIMIT_MAX   = 4095;
    localparam int unsigned DEF_VALUE_LIMIT_MAX  = 65535;
    localparam int unsigned DEF_FIELDS_LIMIT_MAX = 1023;

    // Request operations
    localparam logic [OP_W-1:0] OP_DATA    = 2'd0;
    localparam logic [OP_W-1:0] OP_END     = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NAME  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_VALUE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIELD = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DONE  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ERROR = 3'd5;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_TOO_MANY   = 3'd0;
    localparam logic [ERR_W-1:0] ERR_INVALID    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY_NAME = 3'd2;
    localparam logic [ERR_W-1:0] ERR_NAME_LONG  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_NO_COLON   = 3'd4;
    localparam logic [ERR_W-1:0] ERR_NO_CRLF    = 3'd5;
    localparam logic [ERR_W-1:0] ERR_VALUE_LONG = 3'd6;

    // Parser phases
    localparam int unsigned PH_W = 3;
    localparam logic [PH_W-1:0] PH_NAME     = 3'd0;
    localparam logic [PH_W-1:0] PH_SKIPWS   = 3'd1;
    localparam logic [PH_W-1:0] PH_VALUE    = 3'd2;
    localparam logic [PH_W-1:0] PH_SKIPLINE = 3'd3;
    localparam logic [PH_W-1:0] PH_IDLE     = 3'd4;

    // Deferred value-end events
    localparam int unsigned PEND_W = 2;
    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_CR   = 2'd1;
    localparam logic [PEND_W-1:0] PEND_LF   = 2'd2;
    localparam logic [PEND_W-1:0] PEND_OVER = 2'd3;

    // Characters of interest
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;

    // Space, tab, LF, VT, FF or CR
    function automatic logic is_ws(input logic [BYTE_W-1:0] b);
        return (b inside {CH_SPACE, CH_TAB, CH_LF, 8'h0B, 8'h0C, CH_CR});
    endfunction

endpackage

// ===== design/http_header_field_parser.sv =====
`timescale 1ns / 1ps
// HTTP header field parser: one header byte per request, one result per request.
// Depends on hhfp_pkg for constants, codes and the whitespace test.
//
// Usage
//   Request channel (i_in_valid / o_in_ready) carries an operation and a byte:
//   data byte, end of input or restart. Every accepted request yields exactly
//   one result on the result channel (o_out_valid / i_out_ready): nothing, a
//   name byte, a value byte, a completed field with its lengths and index,
//   headers done, or an error code.
//   The result is registered: it is presented in the cycle after its request is
//   accepted. Throughput is one request per cycle while the receiver takes each
//   result, set by the combinational state update ahead of the result register.
//   The result register parts the channels: a new request is taken while the
//   held result is being taken in the same cycle; when the receiver stalls,
//   the result holds and o_in_ready drops until it is taken.
//   Limits are written through i_cfg_we / i_cfg_index / i_cfg_data, capped at
//   the module parameters, and should only change while no request is in
//   flight. Synchronous reset restores the limits to 100, 256 and 4096 and
//   puts the parser at the start of a name line; a restart request clears the
//   parser state only. After headers done or an error the parser emits
//   nothing until a restart.
module http_header_field_parser
    import hhfp_pkg::*;
#(
    parameter int unsigned NAME_LIMIT_MAX   = DEF_NAME_LIMIT_MAX,
    parameter int unsigned VALUE_LIMIT_MAX  = DEF_VALUE_LIMIT_MAX,
    parameter int unsigned FIELDS_LIMIT_MAX = DEF_FIELDS_LIMIT_MAX
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [BYTE_W-1:0]     i_data_byte,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [KIND_W-1:0]     o_kind,
    output logic [BYTE_W-1:0]     o_out_byte,
    output logic [ERR_W-1:0]      o_error_code,
    output logic [NLEN_W-1:0]     o_name_length,
    output logic [VLEN_W-1:0]     o_value_length,
    output logic [FIDX_W-1:0]     o_field_index
);

    // Limit registers
    logic [MAXF_W-1:0] r_max_fields;
    logic [MAXN_W-1:0] r_max_name_len;
    logic [MAXV_W-1:0] r_max_value_len;

    // Parser state
    logic [PH_W-1:0]   r_phase,         n_phase;
    logic [PEND_W-1:0] r_pend,          n_pend;
    logic [NLEN_W-1:0] r_name_count,    n_name_count;
    logic [VLEN_W-1:0] r_value_count,   n_value_count;
    logic [VLEN_W-1:0] r_trimmed_count, n_trimmed_count;
    logic [FIDX_W-1:0] r_field_count,   n_field_count;

    // Result register
    logic              r_out_valid;
    logic [KIND_W-1:0] r_kind,      n_kind;
    logic [BYTE_W-1:0] r_out_byte,  n_out_byte;
    logic [ERR_W-1:0]  r_err,       n_err;
    logic [NLEN_W-1:0] r_nlen,      n_nlen;
    logic [VLEN_W-1:0] r_vlen,      n_vlen;
    logic [FIDX_W-1:0] r_fidx,      n_fidx;

    logic              in_accept;
    logic              is_end;
    logic              do_value;
    logic              over_fields;
    logic [VLEN_W-1:0] value_inc;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign is_end     = (i_operation == OP_END);
    assign value_inc  = r_value_count + VLEN_W'(1);
    assign over_fields = (r_field_count > {1'b0, r_max_fields});

    // Capture limit writes, masked to width and capped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fields    <= RST_MAX_FIELDS;
            r_max_name_len  <= RST_MAX_NAME_LEN;
            r_max_value_len <= RST_MAX_VALUE_LEN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_FIELDS: begin
                    if (32'(i_cfg_data[MAXF_W-1:0]) > FIELDS_LIMIT_MAX)
                        r_max_fields <= MAXF_W'(FIELDS_LIMIT_MAX);
                    else
                        r_max_fields <= i_cfg_data[MAXF_W-1:0];
                end
                CFG_MAX_NAME_LEN: begin
                    if (32'(i_cfg_data[MAXN_W-1:0]) > NAME_LIMIT_MAX)
                        r_max_name_len <= MAXN_W'(NAME_LIMIT_MAX);
                    else
                        r_max_name_len <= i_cfg_data[MAXN_W-1:0];
                end
                CFG_MAX_VALUE_LEN: begin
                    if (32'(i_cfg_data[MAXV_W-1:0]) > VALUE_LIMIT_MAX)
                        r_max_value_len <= MAXV_W'(VALUE_LIMIT_MAX);
                    else
                        r_max_value_len <= i_cfg_data[MAXV_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Work out the next state and the result of one request
    always_comb begin
        n_phase         = r_phase;
        n_pend          = r_pend;
        n_name_count    = r_name_count;
        n_value_count   = r_value_count;
        n_trimmed_count = r_trimmed_count;
        n_field_count   = r_field_count;
        n_kind          = KIND_NONE;
        n_out_byte      = '0;
        n_err           = '0;
        n_nlen          = '0;
        n_vlen          = '0;
        n_fidx          = '0;
        do_value        = 1'b0;

        if (i_operation == OP_RESTART) begin
            n_phase         = PH_NAME;
            n_pend          = PEND_NONE;
            n_name_count    = '0;
            n_value_count   = '0;
            n_trimmed_count = '0;
            n_field_count   = '0;
        end else if ((i_operation inside {OP_DATA, OP_END}) && r_phase != PH_IDLE) begin
            if (r_pend != PEND_NONE) begin
                // Resolve the value end deferred from the previous byte
                if (is_end) begin
                    n_kind = KIND_ERROR;
                    n_err  = ERR_INVALID;
                end else if (r_pend == PEND_LF) begin
                    n_kind = KIND_ERROR;
                    n_err  = ERR_NO_CRLF;
                end else if (r_pend == PEND_OVER) begin
                    n_kind = KIND_ERROR;
                    n_err  = ERR_VALUE_LONG;
                end else begin
                    n_kind          = KIND_FIELD;
                    n_nlen          = r_name_count;
                    n_vlen          = r_trimmed_count;
                    n_fidx          = r_field_count;
                    n_field_count   = r_field_count + FIDX_W'(1);
                    n_pend          = PEND_NONE;
                    n_name_count    = '0;
                    n_value_count   = '0;
                    n_trimmed_count = '0;
                    n_phase         = (i_data_byte == CH_LF) ? PH_NAME : PH_SKIPLINE;
                end
            end else begin
                case (r_phase)
                    PH_NAME: begin
                        if (r_name_count == '0 && over_fields) begin
                            n_kind = KIND_ERROR;
                            n_err  = ERR_TOO_MANY;
                        end else if (is_end) begin
                            n_kind = KIND_ERROR;
                            n_err  = ERR_INVALID;
                        end else if (r_name_count > {1'b0, r_max_name_len}) begin
                            n_kind = KIND_ERROR;
                            n_err  = ERR_NAME_LONG;
                        end else if (i_data_byte == CH_COLON || is_ws(i_data_byte)) begin
                            if (r_name_count == '0) begin
                                if (i_data_byte == CH_CR) begin
                                    n_phase = PH_IDLE;
                                    n_kind  = KIND_DONE;
                                end else if (i_data_byte == CH_COLON) begin
                                    n_kind = KIND_ERROR;
                                    n_err  = ERR_EMPTY_NAME;
                                end else begin
                                    n_phase = PH_SKIPWS;
                                end
                            end else if (i_data_byte == CH_COLON) begin
                                n_phase = PH_SKIPWS;
                            end else begin
                                n_kind = KIND_ERROR;
                                n_err  = ERR_NO_COLON;
                            end
                        end else begin
                            n_name_count = r_name_count + NLEN_W'(1);
                            n_kind       = KIND_NAME;
                            n_out_byte   = i_data_byte;
                        end
                    end
                    PH_SKIPWS: begin
                        if (is_end) begin
                            n_kind = KIND_ERROR;
                            n_err  = ERR_INVALID;
                        end else if (i_data_byte != CH_SPACE && i_data_byte != CH_TAB) begin
                            n_phase  = PH_VALUE;
                            do_value = 1'b1;
                        end
                    end
                    PH_VALUE: begin
                        if (is_end) begin
                            n_kind = KIND_ERROR;
                            n_err  = ERR_INVALID;
                        end else begin
                            do_value = 1'b1;
                        end
                    end
                    default: begin
                        // Skip through LF
                        if (is_end) begin
                            n_kind = KIND_ERROR;
                            n_err  = over_fields ? ERR_TOO_MANY : ERR_INVALID;
                        end else if (i_data_byte == CH_LF) begin
                            n_phase = PH_NAME;
                        end
                    end
                endcase

                // Take a value byte or defer the value end
                if (do_value) begin
                    if (i_data_byte == CH_LF) begin
                        n_pend = PEND_LF;
                    end else if (r_value_count > {1'b0, r_max_value_len}) begin
                        n_pend = PEND_OVER;
                    end else if (i_data_byte == CH_CR) begin
                        n_pend = PEND_CR;
                    end else begin
                        n_value_count = value_inc;
                        if (!is_ws(i_data_byte))
                            n_trimmed_count = value_inc;
                        n_kind     = KIND_VALUE;
                        n_out_byte = i_data_byte;
                    end
                end
            end

            // Any error parks the parser
            if (n_kind == KIND_ERROR) begin
                n_phase = PH_IDLE;
                n_pend  = PEND_NONE;
            end
        end
    end

    // Advance parser state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_NAME;
            r_pend          <= PEND_NONE;
            r_name_count    <= '0;
            r_value_count   <= '0;
            r_trimmed_count <= '0;
            r_field_count   <= '0;
        end else if (in_accept) begin
            r_phase         <= n_phase;
            r_pend          <= n_pend;
            r_name_count    <= n_name_count;
            r_value_count   <= n_value_count;
            r_trimmed_count <= n_trimmed_count;
            r_field_count   <= n_field_count;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind     <= n_kind;
            r_out_byte <= n_out_byte;
            r_err      <= n_err;
            r_nlen     <= n_nlen;
            r_vlen     <= n_vlen;
            r_fidx     <= n_fidx;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_out_byte     = r_out_byte;
    assign o_error_code   = r_err;
    assign o_name_length  = r_nlen;
    assign o_value_length = r_vlen;
    assign o_field_index  = r_fidx;

    // A deferred value end only exists inside a value
    a_pend_in_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != PEND_NONE) |-> (r_phase == PH_VALUE))
        else $error("deferred value event outside value phase");

    // Trimmed length never runs ahead of the value length
    a_trim_le_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trimmed_count <= r_value_count)
        else $error("trimmed length exceeds value length");

    // Restart returns the parser to the start of a name line
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_operation == OP_RESTART) |=>
            (r_phase == PH_NAME && r_pend == PEND_NONE &&
             r_name_count == '0 && r_field_count == '0))
        else $error("restart did not clear parser state");

    // A stalled receiver blocks new requests
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !in_accept)
        else $error("request taken while result stalled");

endmodule

// ===== tb/http_header_field_parser_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for http_header_field_parser: header byte streams in, parse results out.
// Depends on hhfp_pkg and the parser RTL; a scoreboard class predicts and checks every result.

import hhfp_pkg::*;

// Operation code the parser treats as a no-op
localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

typedef struct {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] out_byte;
    logic [ERR_W-1:0]  error_code;
    logic [NLEN_W-1:0] name_length;
    logic [VLEN_W-1:0] value_length;
    logic [FIDX_W-1:0] field_index;
} t_parse_result;

class header_scoreboard;
    // Limit registers as the parser should hold them
    logic [MAXF_W-1:0] lim_fields;
    logic [MAXN_W-1:0] lim_name;
    logic [MAXV_W-1:0] lim_value;

    // Parser state
    logic [PH_W-1:0]   phase;
    logic [PEND_W-1:0] pending;
    logic [NLEN_W-1:0] name_cnt;
    logic [VLEN_W-1:0] value_cnt;
    logic [VLEN_W-1:0] trimmed_cnt;
    logic [FIDX_W-1:0] field_cnt;

    t_parse_result expected_results[$];
    int mismatches;
    int results_checked;
    int parsed_requests;
    int kind_seen[6];
    int errors_seen[7];

    function void reset_model();
        lim_fields = RST_MAX_FIELDS;
        lim_name   = RST_MAX_NAME_LEN;
        lim_value  = RST_MAX_VALUE_LEN;
        clear_parser();
    endfunction

    function void clear_parser();
        phase       = PH_NAME;
        pending     = PEND_NONE;
        name_cnt    = '0;
        value_cnt   = '0;
        trimmed_cnt = '0;
        field_cnt   = '0;
    endfunction

    // Mask to the register width, then cap at the limit ceiling
    function void apply_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        int unsigned v;
        case (idx)
            CFG_MAX_FIELDS: begin
                v = data[MAXF_W-1:0];
                lim_fields = MAXF_W'((v > DEF_FIELDS_LIMIT_MAX) ? DEF_FIELDS_LIMIT_MAX : v);
            end
            CFG_MAX_NAME_LEN: begin
                v = data[MAXN_W-1:0];
                lim_name = MAXN_W'((v > DEF_NAME_LIMIT_MAX) ? DEF_NAME_LIMIT_MAX : v);
            end
            CFG_MAX_VALUE_LEN: begin
                v = data[MAXV_W-1:0];
                lim_value = MAXV_W'((v > DEF_VALUE_LIMIT_MAX) ? DEF_VALUE_LIMIT_MAX : v);
            end
            default: ;
        endcase
    endfunction

    // Space, tab and the control bytes LF through CR
    function bit is_blank(logic [BYTE_W-1:0] b);
        return (b >= CH_TAB && b <= CH_CR) || b == CH_SPACE;
    endfunction

    function t_parse_result fault(logic [ERR_W-1:0] code);
        t_parse_result r;
        r = '{default: '0};
        phase   = PH_IDLE;
        pending = PEND_NONE;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    function t_parse_result next_result(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b);
        t_parse_result r;
        bit fin;
        r = '{default: '0};
        fin = (op == OP_END);

        if (op == OP_RESTART) begin
            clear_parser();
            return r;
        end
        if (op == OP_UNUSED || phase == PH_IDLE)
            return r;

        // A value ended on the previous byte: settle it now
        if (pending != PEND_NONE) begin
            if (fin)
                return fault(ERR_INVALID);
            if (pending == PEND_LF)
                return fault(ERR_NO_CRLF);
            if (pending == PEND_OVER)
                return fault(ERR_VALUE_LONG);
            r.kind         = KIND_FIELD;
            r.name_length  = name_cnt;
            r.value_length = trimmed_cnt;
            r.field_index  = field_cnt;
            field_cnt   = field_cnt + 1'b1;
            pending     = PEND_NONE;
            name_cnt    = '0;
            value_cnt   = '0;
            trimmed_cnt = '0;
            phase = (b == CH_LF) ? PH_NAME : PH_SKIPLINE;
            return r;
        end

        if (phase == PH_NAME) begin
            if (name_cnt == 0 && field_cnt > lim_fields)
                return fault(ERR_TOO_MANY);
            if (fin)
                return fault(ERR_INVALID);
            if (name_cnt > lim_name)
                return fault(ERR_NAME_LONG);
            if (b == CH_COLON || is_blank(b)) begin
                if (name_cnt == 0) begin
                    if (b == CH_CR) begin
                        phase  = PH_IDLE;
                        r.kind = KIND_DONE;
                        return r;
                    end
                    if (b == CH_COLON)
                        return fault(ERR_EMPTY_NAME);
                    phase = PH_SKIPWS;
                end else if (b == CH_COLON) begin
                    phase = PH_SKIPWS;
                end else begin
                    return fault(ERR_NO_COLON);
                end
                return r;
            end
            name_cnt   = name_cnt + 1'b1;
            r.kind     = KIND_NAME;
            r.out_byte = b;
            return r;
        end

        if (phase == PH_SKIPWS || phase == PH_VALUE) begin
            if (fin)
                return fault(ERR_INVALID);
            if (phase == PH_SKIPWS) begin
                if (b == CH_SPACE || b == CH_TAB)
                    return r;
                phase = PH_VALUE;
            end
            // LF beats overflow, overflow beats CR
            if (b == CH_LF) begin
                pending = PEND_LF;
            end else if (value_cnt > lim_value) begin
                pending = PEND_OVER;
            end else if (b == CH_CR) begin
                pending = PEND_CR;
            end else begin
                value_cnt = value_cnt + 1'b1;
                if (!is_blank(b))
                    trimmed_cnt = value_cnt;
                r.kind     = KIND_VALUE;
                r.out_byte = b;
            end
            return r;
        end

        // Skipping the rest of a line
        if (fin) begin
            if (field_cnt > lim_fields)
                return fault(ERR_TOO_MANY);
            return fault(ERR_INVALID);
        end
        if (b == CH_LF)
            phase = PH_NAME;
        return r;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b);
        if (op == OP_RESTART || (op != OP_UNUSED && phase != PH_IDLE))
            parsed_requests++;
        expected_results.push_back(next_result(op, b));
    endfunction

    function int outstanding();
        return expected_results.size();
    endfunction

    task report_mismatch(string what);
        mismatches++;
        if (mismatches <= 100)
            $display("[%0t] mismatch at result %0d: %s", $time, results_checked, what);
    endtask

    task check_result(t_parse_result got);
        t_parse_result want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result of kind %0d with no request outstanding",
                                      got.kind));
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
        if (got.error_code !== want.error_code)
            report_mismatch($sformatf("error_code %0d, want %0d",
                                      got.error_code, want.error_code));
        if (got.name_length !== want.name_length)
            report_mismatch($sformatf("name_length %0d, want %0d",
                                      got.name_length, want.name_length));
        if (got.value_length !== want.value_length)
            report_mismatch($sformatf("value_length %0d, want %0d",
                                      got.value_length, want.value_length));
        if (got.field_index !== want.field_index)
            report_mismatch($sformatf("field_index %0d, want %0d",
                                      got.field_index, want.field_index));
        if (want.kind <= KIND_ERROR)
            kind_seen[want.kind]++;
        if (want.kind == KIND_ERROR)
            errors_seen[want.error_code]++;
    endtask
endclass

module http_header_field_parser_test;

    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [OP_W-1:0]       i_operation = OP_DATA;
    logic [BYTE_W-1:0]     i_data_byte = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [KIND_W-1:0]     o_kind;
    logic [BYTE_W-1:0]     o_out_byte;
    logic [ERR_W-1:0]      o_error_code;
    logic [NLEN_W-1:0]     o_name_length;
    logic [VLEN_W-1:0]     o_value_length;
    logic [FIDX_W-1:0]     o_field_index;

    header_scoreboard sb;
    t_parse_result    seen;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               cycles         = 0;

    http_header_field_parser u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_out_byte     (o_out_byte),
        .o_error_code   (o_error_code),
        .o_name_length  (o_name_length),
        .o_value_length (o_value_length),
        .o_field_index  (o_field_index)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Abandon the run if it hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("http_header_field_parser_test NOT OK");
            $finish;
        end
    end

    // Stall the result channel at the current rate
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Take each accepted result and check it
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.kind         = o_kind;
            seen.out_byte     = o_out_byte;
            seen.error_code   = o_error_code;
            seen.name_length  = o_name_length;
            seen.value_length = o_value_length;
            seen.field_index  = o_field_index;
            sb.check_result(seen);
        end
    end

    // Called just after a falling edge; returns just after the next one
    task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        sb.apply_limit(idx, data);
    endtask

    task automatic set_limits(logic [CFG_DATA_W-1:0] fields, logic [CFG_DATA_W-1:0] name,
                              logic [CFG_DATA_W-1:0] value);
        write_limit(CFG_MAX_FIELDS, fields);
        write_limit(CFG_MAX_NAME_LEN, name);
        write_limit(CFG_MAX_VALUE_LEN, value);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offer one request, with random idle cycles ahead of it, and hold it until taken
    task automatic send_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_data_byte <= b;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sb.note_request(op, b);
        @(negedge i_clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_request(OP_DATA, s[i]);
    endtask

    // Data byte, now and then preceded by a stray request of any operation
    task automatic send_byte(logic [BYTE_W-1:0] b);
        if ($urandom_range(0, 99) < 2)
            send_request(OP_W'($urandom), BYTE_W'($urandom));
        send_request(OP_DATA, b);
    endtask

    // Drop valid and wait for every outstanding result, then settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.outstanding() > 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] name_char();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom);
        while (sb.is_blank(b) || b == CH_COLON);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] value_char();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom);
        while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] blank_char();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return 8'h0B;
            default: return 8'h0C;
        endcase
    endfunction

    // One header block: restart, a few field lines with random content, then an ending
    task automatic send_header_block();
        int lines;
        int cap;
        int name_len;
        int value_len;
        int trail;
        int pick;
        send_request(OP_RESTART, BYTE_W'($urandom));
        cap   = (sb.lim_fields < 4) ? sb.lim_fields + 2 : 4;
        lines = $urandom_range(0, cap);
        for (int ln = 0; ln < lines && sb.phase != PH_IDLE; ln++) begin
            // Name, mostly within the limit, sometimes empty or up to two over
            cap      = (sb.lim_name < 8) ? sb.lim_name + 2 : 8;
            name_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, cap);
            for (int i = 0; i < name_len; i++)
                send_byte(name_char());
            if (name_len > 0) begin
                send_byte(CH_COLON);
            end else begin
                case ($urandom_range(0, 5))
                    0:       send_byte(CH_COLON);
                    1:       send_byte(CH_LF);
                    default: send_byte(blank_char());
                endcase
            end
            repeat ($urandom_range(0, 2)) send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);

            // Value, sometimes with trailing blanks
            cap       = (sb.lim_value < 10) ? sb.lim_value + 2 : 10;
            value_len = $urandom_range(0, cap);
            trail     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
            for (int i = 0; i < value_len; i++)
                send_byte((i >= value_len - trail) ? blank_char() : value_char());

            // Line ending
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end else if (pick < 88) begin
                send_byte(CH_CR);
                repeat ($urandom_range(1, 3)) send_byte(value_char());
                send_byte(CH_LF);
            end else if (pick < 94) begin
                send_byte(CH_LF);
                send_byte(value_char());
            end else begin
                send_request(OP_END, BYTE_W'($urandom));
            end
        end
        if (sb.phase != PH_IDLE) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_byte(CH_CR);
            else if (pick < 85)
                send_request(OP_END, BYTE_W'($urandom));
            else
                repeat (3) send_request(OP_W'($urandom), BYTE_W'($urandom));
        end
    endtask

    initial begin
        int budget;
        sb = new();
        sb.reset_model();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: tight limits so every error is a few bytes away
        set_limits(0, 1, 2);
        // Field with extreme bytes, skipped blanks, trailing blank, CR then junk to LF
        send_request(OP_DATA, 8'hFF);
        send_text(": \t");
        send_request(OP_DATA, 8'h00);
        send_request(OP_DATA, CH_SPACE);
        send_request(OP_DATA, CH_CR);
        send_text("XY");
        send_request(OP_DATA, CH_LF);
        // Second line over the field limit, then idle and the unused operation
        send_text("ab");
        send_request(OP_UNUSED, 8'hA5);
        // Blank line ends the headers
        send_request(OP_RESTART, 8'h00);
        send_request(OP_DATA, CH_CR);
        // Colon at line start
        send_request(OP_RESTART, 8'hFF);
        send_text(":");
        // Name one over the limit, then any byte
        send_request(OP_RESTART, 8'h00);
        send_text("abc");
        // Blank inside a name
        send_request(OP_RESTART, 8'h00);
        send_text("a ");
        // Empty name taken as separator; LF in value then end of input
        send_request(OP_RESTART, 8'h00);
        send_request(OP_DATA, 8'h0C);
        send_text("v");
        send_request(OP_DATA, CH_LF);
        send_request(OP_END, 8'hFF);
        // Value overflow
        send_request(OP_RESTART, 8'h00);
        send_request(OP_DATA, CH_TAB);
        send_text("vwyzq");

        // Random header blocks under several limit settings and pacing modes
        for (int p = 0; p < 8; p++) begin
            drain();
            case (p)
                0: set_limits(1023, 4095, 65535);
                1: set_limits(0, 0, 0);
                2: set_limits(3, 6, 8);
                3: set_limits(2, 3, 4);
                4: set_limits(RST_MAX_FIELDS, RST_MAX_NAME_LEN, RST_MAX_VALUE_LEN);
                5: set_limits($urandom_range(0, 4), $urandom_range(0, 8), $urandom_range(0, 10));
                6: set_limits($urandom, $urandom, $urandom);
                default: set_limits(1, 2, 3);
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            budget = sb.parsed_requests + 94;
            while (sb.parsed_requests < budget)
                send_header_block();
        end

        drain();
        repeat (8) @(negedge i_clk);

        $display("Covered %0d parse requests and %0d results under eight limit settings",
                 sb.parsed_requests, sb.results_checked);
        $display("Fields %0d, header ends %0d, errors by code %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 sb.kind_seen[KIND_FIELD], sb.kind_seen[KIND_DONE],
                 sb.errors_seen[ERR_TOO_MANY], sb.errors_seen[ERR_INVALID],
                 sb.errors_seen[ERR_EMPTY_NAME], sb.errors_seen[ERR_NAME_LONG],
                 sb.errors_seen[ERR_NO_COLON], sb.errors_seen[ERR_NO_CRLF],
                 sb.errors_seen[ERR_VALUE_LONG]);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("http_header_field_parser_test OK");
        else
            $display("http_header_field_parser_test NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
design/hhfp_pkg.sv
design/http_header_field_parser.sv
tb/http_header_field_parser_test.sv
